[sv/mcpg_pkg.sv]
// ----------------------------------------------------------------------------
// mcpg_pkg
// shared types, constants and the level colour table of the mipmap
// checkerboard pattern generator
// ----------------------------------------------------------------------------
package mcpg_pkg;

  localparam int SIZE_W   = 14;
  localparam int COORD_W  = 13;
  localparam int LEVEL_W  = 4;
  localparam int COUNT_W  = 27;
  localparam int OFFSET_W = 29;
  localparam int COLOR_W  = 8;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_GRID_SIZE  = 8;
  localparam int DEF_MAX_LEVELS = 14;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(8192);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_WIDTH  = 2'd0,
    CFG_BASE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic                active;
    logic [LEVEL_W-1:0]  level;
    logic [COORD_W-1:0]  coord_s;
    logic [COORD_W-1:0]  coord_t;
    logic                parity;
    logic [COUNT_W-1:0]  texel_count;
    logic                level_end;
    logic                image_end;
  } scan_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > SIZE_LIMIT) r = SIZE_LIMIT;
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] halve_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] h;
    h = v >> 1;
    if (h == '0) h = SIZE_W'(1);
    return h;
  endfunction

  // foreground on even parity, background on odd parity
  function automatic rgb_t level_colour(input logic [LEVEL_W-1:0] level,
                                        input logic parity);
    rgb_t fg;
    rgb_t bg;
    unique case (level)
      4'd0:    fg = '{8'hff, 8'hff, 8'hff};
      4'd1:    fg = '{8'hff, 8'h00, 8'h00};
      4'd2:    fg = '{8'h00, 8'hff, 8'hff};
      4'd3:    fg = '{8'h00, 8'hff, 8'h00};
      4'd4:    fg = '{8'hff, 8'h00, 8'hff};
      4'd5:    fg = '{8'h00, 8'h00, 8'hff};
      4'd6:    fg = '{8'hff, 8'hff, 8'h00};
      4'd7:    fg = '{8'hff, 8'hff, 8'hff};
      4'd8:    fg = '{8'hff, 8'h00, 8'h00};
      4'd9:    fg = '{8'h00, 8'hff, 8'hff};
      4'd10:   fg = '{8'h00, 8'hff, 8'h00};
      4'd11:   fg = '{8'hff, 8'h00, 8'hff};
      4'd12:   fg = '{8'h00, 8'h00, 8'hff};
      default: fg = '{8'hff, 8'hff, 8'h00};
    endcase
    if (level > 4'd13) bg = '{8'hff, 8'hff, 8'hff};
    else if (level[0]) bg = '{8'hff, 8'hff, 8'hff};
    else bg = '{8'h00, 8'h00, 8'h00};
    return parity ? bg : fg;
  endfunction

endpackage

[sv/mcpg_front.sv]
// ----------------------------------------------------------------------------
// mcpg_front
// size registers and scan state: takes restart/advance transactions and
// pushes one classified texel descriptor per transaction into the queue
// ----------------------------------------------------------------------------
module mcpg_front #(
  parameter int GRID_SIZE  = mcpg_pkg::DEF_GRID_SIZE,
  parameter int MAX_LEVELS = mcpg_pkg::DEF_MAX_LEVELS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_restart,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mcpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcpg_pkg::SIZE_W-1:0]      cfg_data,
  input  logic                             q_full,
  output logic                             q_push,
  output mcpg_pkg::scan_item_t             q_item
);

  localparam int SUB_W = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(GRID_SIZE - 1);
  localparam int LVL_CMP_W = mcpg_pkg::LEVEL_W + 1;
  localparam logic [LVL_CMP_W-1:0] LEVEL_LIMIT = LVL_CMP_W'(MAX_LEVELS);

  logic [mcpg_pkg::SIZE_W-1:0]  base_w_r, base_h_r;
  logic [mcpg_pkg::COORD_W-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [SUB_W-1:0]             col_sub_r, row_sub_r, col_sub_nxt, row_sub_nxt;
  logic                         col_par_r, row_par_r, col_par_nxt, row_par_nxt;
  logic [mcpg_pkg::LEVEL_W-1:0] level_r, level_nxt;
  logic [mcpg_pkg::SIZE_W-1:0]  lw_r, lh_r, lw_nxt, lh_nxt;
  logic [mcpg_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic                         fin_r, fin_nxt;

  logic [mcpg_pkg::COORD_W-1:0] e_col, e_row;
  logic [SUB_W-1:0]             e_col_sub, e_row_sub;
  logic                         e_col_par, e_row_par;
  logic [mcpg_pkg::LEVEL_W-1:0] e_level;
  logic [mcpg_pkg::SIZE_W-1:0]  e_lw, e_lh;
  logic [mcpg_pkg::COUNT_W-1:0] e_cnt;
  logic                         e_fin;
  logic                         last_col, last_row, last_level;
  logic                         accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;
  assign q_push    = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_w_r <= mcpg_pkg::SIZE_RESET;
      base_h_r <= mcpg_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == mcpg_pkg::CFG_BASE_WIDTH) base_w_r <= cfg_data;
      if (cfg_index == mcpg_pkg::CFG_BASE_HEIGHT) base_h_r <= cfg_data;
    end
  end

  // state as seen by this transaction, after an optional reload
  always_comb begin
    if (in_restart) begin
      e_col     = '0;
      e_row     = '0;
      e_col_sub = '0;
      e_row_sub = '0;
      e_col_par = 1'b0;
      e_row_par = 1'b0;
      e_level   = '0;
      e_lw      = mcpg_pkg::clamp_size(base_w_r);
      e_lh      = mcpg_pkg::clamp_size(base_h_r);
      e_cnt     = '0;
      e_fin     = 1'b0;
    end else begin
      e_col     = col_r;
      e_row     = row_r;
      e_col_sub = col_sub_r;
      e_row_sub = row_sub_r;
      e_col_par = col_par_r;
      e_row_par = row_par_r;
      e_level   = level_r;
      e_lw      = lw_r;
      e_lh      = lh_r;
      e_cnt     = cnt_r;
      e_fin     = fin_r;
    end
  end

  assign last_col   = ({1'b0, e_col} + mcpg_pkg::SIZE_W'(1)) >= e_lw;
  assign last_row   = ({1'b0, e_row} + mcpg_pkg::SIZE_W'(1)) >= e_lh;
  assign last_level = ((e_lw == mcpg_pkg::SIZE_W'(1)) && (e_lh == mcpg_pkg::SIZE_W'(1))) ||
                      (({1'b0, e_level} + LVL_CMP_W'(1)) >= LEVEL_LIMIT);

  always_comb begin
    q_item = '0;
    if (!e_fin) begin
      q_item.active      = 1'b1;
      q_item.level       = e_level;
      q_item.coord_s     = e_col;
      q_item.coord_t     = e_row;
      q_item.parity      = e_col_par ^ e_row_par ^ e_level[0];
      q_item.texel_count = e_cnt;
      q_item.level_end   = last_col && last_row;
      q_item.image_end   = last_col && last_row && last_level;
    end
  end

  always_comb begin
    col_nxt     = e_col;
    row_nxt     = e_row;
    col_sub_nxt = e_col_sub;
    row_sub_nxt = e_row_sub;
    col_par_nxt = e_col_par;
    row_par_nxt = e_row_par;
    level_nxt   = e_level;
    lw_nxt      = e_lw;
    lh_nxt      = e_lh;
    cnt_nxt     = e_cnt;
    fin_nxt     = e_fin;
    if (!e_fin) begin
      cnt_nxt = e_cnt + mcpg_pkg::COUNT_W'(1);
      if (!last_col) begin
        col_nxt = e_col + mcpg_pkg::COORD_W'(1);
        if (e_col_sub == SUB_LAST) begin
          col_sub_nxt = '0;
          col_par_nxt = !e_col_par;
        end else begin
          col_sub_nxt = e_col_sub + SUB_W'(1);
        end
      end else begin
        col_nxt     = '0;
        col_sub_nxt = '0;
        col_par_nxt = 1'b0;
        if (!last_row) begin
          row_nxt = e_row + mcpg_pkg::COORD_W'(1);
          if (e_row_sub == SUB_LAST) begin
            row_sub_nxt = '0;
            row_par_nxt = !e_row_par;
          end else begin
            row_sub_nxt = e_row_sub + SUB_W'(1);
          end
        end else begin
          row_nxt     = '0;
          row_sub_nxt = '0;
          row_par_nxt = 1'b0;
          if (last_level) begin
            fin_nxt = 1'b1;
          end else begin
            level_nxt = e_level + mcpg_pkg::LEVEL_W'(1);
            lw_nxt    = mcpg_pkg::halve_size(e_lw);
            lh_nxt    = mcpg_pkg::halve_size(e_lh);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      col_sub_r <= '0;
      row_sub_r <= '0;
      col_par_r <= 1'b0;
      row_par_r <= 1'b0;
      level_r   <= '0;
      lw_r      <= mcpg_pkg::SIZE_RESET;
      lh_r      <= mcpg_pkg::SIZE_RESET;
      cnt_r     <= '0;
      fin_r     <= 1'b0;
    end else if (accept) begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      col_sub_r <= col_sub_nxt;
      row_sub_r <= row_sub_nxt;
      col_par_r <= col_par_nxt;
      row_par_r <= row_par_nxt;
      level_r   <= level_nxt;
      lw_r      <= lw_nxt;
      lh_r      <= lh_nxt;
      cnt_r     <= cnt_nxt;
      fin_r     <= fin_nxt;
    end
  end

  a_image_end_ends_level: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_item.image_end |-> q_item.level_end)
    else $error("image end without level end");

  a_finish_on_image_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_item.image_end |=> fin_r)
    else $error("scan not finished after last texel");

endmodule

[sv/mcpg_queue.sv]
// ----------------------------------------------------------------------------
// mcpg_queue
// short descriptor queue between the scan front and the colour back end
// ----------------------------------------------------------------------------
module mcpg_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mcpg_pkg::scan_item_t push_item,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output mcpg_pkg::scan_item_t head_item
);

  localparam int PTR_W = (mcpg_pkg::QUEUE_DEPTH > 1) ? $clog2(mcpg_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(mcpg_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(mcpg_pkg::QUEUE_DEPTH - 1);

  mcpg_pkg::scan_item_t entry_r [mcpg_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(mcpg_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop) rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

[sv/mcpg_back.sv]
// ----------------------------------------------------------------------------
// mcpg_back
// colour lookup and registered result stage
// ----------------------------------------------------------------------------
module mcpg_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_not_empty,
  input  mcpg_pkg::scan_item_t              q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_active,
  output logic [mcpg_pkg::LEVEL_W-1:0]      out_level,
  output logic [mcpg_pkg::COORD_W-1:0]      out_coord_s,
  output logic [mcpg_pkg::COORD_W-1:0]      out_coord_t,
  output logic [mcpg_pkg::COLOR_W-1:0]      out_red,
  output logic [mcpg_pkg::COLOR_W-1:0]      out_green,
  output logic [mcpg_pkg::COLOR_W-1:0]      out_blue,
  output logic [mcpg_pkg::OFFSET_W-1:0]     out_byte_offset,
  output logic                              out_level_end,
  output logic                              out_image_end
);

  logic          valid_r;
  mcpg_pkg::rgb_t colour;
  mcpg_pkg::rgb_t rgb_r;
  mcpg_pkg::scan_item_t item_r;

  assign q_pop = q_not_empty && (!valid_r || !out_stall);

  always_comb begin
    colour = '0;
    if (q_item.active) colour = mcpg_pkg::level_colour(q_item.level, q_item.parity);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
      rgb_r  <= colour;
    end
  end

  assign out_valid       = valid_r;
  assign out_active      = item_r.active;
  assign out_level       = item_r.level;
  assign out_coord_s     = item_r.coord_s;
  assign out_coord_t     = item_r.coord_t;
  assign out_red         = rgb_r.red;
  assign out_green       = rgb_r.green;
  assign out_blue        = rgb_r.blue;
  assign out_byte_offset = {item_r.texel_count, 2'b00};
  assign out_level_end   = item_r.level_end;
  assign out_image_end   = item_r.image_end;

  a_inactive_is_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_active |-> (out_red == '0) && (out_byte_offset == '0))
    else $error("finished result carries data");

endmodule

[sv/mipmap_checker_pattern_generator.sv]
// ----------------------------------------------------------------------------
// mipmap_checker_pattern_generator
// checkerboard test pattern for a mipmapped rgba texture, one texel per
// transaction
// result path: each accepted transaction is registered in a queue entry and then
// in the back-end result register before it is presented at the outputs
// throughput: one texel per cycle while out_stall is low, sustained through the two-entry queue
// the scan front updates its counters once per accepted transaction
// reset: sizes return to 256 by 256 and the scan restarts at level zero
// ----------------------------------------------------------------------------
module mipmap_checker_pattern_generator #(
  parameter int GRID_SIZE  = mcpg_pkg::DEF_GRID_SIZE,
  parameter int MAX_LEVELS = mcpg_pkg::DEF_MAX_LEVELS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_active,
  output logic [mcpg_pkg::LEVEL_W-1:0]      out_level,
  output logic [mcpg_pkg::COORD_W-1:0]      out_coord_s,
  output logic [mcpg_pkg::COORD_W-1:0]      out_coord_t,
  output logic [mcpg_pkg::COLOR_W-1:0]      out_red,
  output logic [mcpg_pkg::COLOR_W-1:0]      out_green,
  output logic [mcpg_pkg::COLOR_W-1:0]      out_blue,
  output logic [mcpg_pkg::OFFSET_W-1:0]     out_byte_offset,
  output logic                              out_level_end,
  output logic                              out_image_end,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mcpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mcpg_pkg::SIZE_W-1:0]       cfg_data
);

  logic                 q_full, q_push, q_pop, q_not_empty;
  mcpg_pkg::scan_item_t push_item, head_item;

  mcpg_front #(
    .GRID_SIZE  (GRID_SIZE),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  mcpg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  mcpg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_item          (head_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_active      (out_active),
    .out_level       (out_level),
    .out_coord_s     (out_coord_s),
    .out_coord_t     (out_coord_t),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_byte_offset (out_byte_offset),
    .out_level_end   (out_level_end),
    .out_image_end   (out_image_end)
  );

endmodule
